### rtl/egbb_pkg.sv
// Shared types and constants of the edge-gated box blur.
// Used by egbb_grad and edge_gated_box_blur; depends on nothing.
package egbb_pkg;

  localparam int PIX_W      = 48;  // edge RGB in [23:0], color RGB in [47:24]
  localparam int CHAN_W     = 8;
  localparam int CFG_DIM_W  = 11;
  localparam int THRESH_W   = 23;
  localparam int SQ_W       = 20;  // one squared gradient, at most 1020*1020
  localparam int GRAD_W     = 11;  // signed gradient, -1020..1020
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 11'd1024;
  localparam logic [THRESH_W-1:0]  THRESH_RST = 23'd1;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } cfg_idx_t;

  // 3x3 window: [row][col][bits], row 0 is the oldest line, col 2 the newest pixel
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic res;       // this item produces an output pixel
    logic interior;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic [3*CHAN_W-1:0] rgb;  // red in the low byte
    logic                blurred;
    logic                last;
  } res_t;

endpackage

### rtl/egbb_grad.sv
// Window arithmetic: Sobel gradients, squared sum, threshold and box blur.
// Two register stages; depends on egbb_pkg.
module egbb_grad (
  input  logic                          clk,
  input  logic                          rst_n,
  input  egbb_pkg::win_t                win,
  input  egbb_pkg::ctl_t                ctl,
  input  logic [egbb_pkg::THRESH_W-1:0] thresh,
  output logic                          res_vld,
  output egbb_pkg::res_t                res,
  output logic [1:0]                    pend
);
  import egbb_pkg::*;

  // floor(v/9) for 8-bit v via reciprocal 57/512, exact over 0..255
  function automatic logic [4:0] div9(input logic [CHAN_W-1:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd57;
    return p[13:9];
  endfunction

  ctl_t                     a_ctl_r, b_ctl_r;
  logic signed [GRAD_W-1:0] a_gx_r [3];
  logic signed [GRAD_W-1:0] a_gy_r [3];
  logic [3*CHAN_W-1:0]      a_blur_r, a_cent_r, b_blur_r, b_cent_r;
  logic [SQ_W-1:0]          b_sq_r [6];

  logic signed [GRAD_W-1:0] gx [3];
  logic signed [GRAD_W-1:0] gy [3];
  logic [9:0]               px, nx, py, ny;
  logic [CHAN_W-1:0]        bsum;
  logic [3*CHAN_W-1:0]      blur, cent;
  logic signed [2*GRAD_W-1:0] sq [6];
  logic [THRESH_W-1:0]      total;
  logic                     edge_hit;

  // stage a: gradients and blur sums from the window
  always_comb begin
    blur = '0;
    cent = '0;
    for (int k = 0; k < 3; k++) begin
      px = 10'(win[0][2][8*k +: 8]) + {1'b0, win[1][2][8*k +: 8], 1'b0}
         + 10'(win[2][2][8*k +: 8]);
      nx = 10'(win[0][0][8*k +: 8]) + {1'b0, win[1][0][8*k +: 8], 1'b0}
         + 10'(win[2][0][8*k +: 8]);
      py = 10'(win[2][0][8*k +: 8]) + {1'b0, win[2][1][8*k +: 8], 1'b0}
         + 10'(win[2][2][8*k +: 8]);
      ny = 10'(win[0][0][8*k +: 8]) + {1'b0, win[0][1][8*k +: 8], 1'b0}
         + 10'(win[0][2][8*k +: 8]);
      gx[k] = $signed({1'b0, px}) - $signed({1'b0, nx});
      gy[k] = $signed({1'b0, py}) - $signed({1'b0, ny});
      bsum = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          bsum = bsum + 8'(div9(win[r][c][24 + 8*k +: 8]));
        end
      end
      blur[8*k +: 8] = bsum;
      cent[8*k +: 8] = win[1][1][24 + 8*k +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
    end else begin
      a_ctl_r <= ctl;
      b_ctl_r <= a_ctl_r;
    end
  end

  // stage b: squares
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq[2*k]   = a_gx_r[k] * a_gx_r[k];
      sq[2*k+1] = a_gy_r[k] * a_gy_r[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      a_gx_r[k] <= gx[k];
      a_gy_r[k] <= gy[k];
    end
    a_blur_r <= blur;
    a_cent_r <= cent;
    for (int i = 0; i < 6; i++) begin
      b_sq_r[i] <= sq[i][SQ_W-1:0];
    end
    b_blur_r <= a_blur_r;
    b_cent_r <= a_cent_r;
  end

  // last stage: sum, compare, select
  always_comb begin
    total = '0;
    for (int i = 0; i < 6; i++) begin
      total = total + THRESH_W'(b_sq_r[i]);
    end
    edge_hit    = b_ctl_r.interior && (total >= thresh);
    res.rgb     = edge_hit ? b_blur_r : b_cent_r;
    res.blurred = edge_hit;
    res.last    = b_ctl_r.last;
    res_vld     = b_ctl_r.res;
    pend        = 2'(a_ctl_r.res) + 2'(b_ctl_r.res);
  end

endmodule

### rtl/edge_gated_box_blur.sv
// Top level of the edge-gated 3x3 box blur: line memory, window, counters
// and output queue. Depends on egbb_pkg and egbb_grad.
//
// Usage: pixels enter in raster order on the in_ channel, one request per
// pixel carrying the edge-image RGB and the color-image RGB; in_tuser marks a
// pad request, whose data is taken as zero. The first frame_width+1 requests
// of a frame produce nothing; after that every request produces the output
// pixel frame_width+1 places earlier in raster order, so a frame is flushed
// with frame_width+1 pad requests. out_tlast marks the last pixel of the
// frame, out_tuser marks a pixel that was blurred (interior and edge).
// Throughput: one request per cycle while in_tready is high, set by the line
// memory, which takes one read and one write per cycle. A pixel's result
// passes stage 1, the window and both egbb_grad stages before the queue.
// Results go through an 8-entry queue; when the receiver stalls, requests
// keep being accepted until the queue plus the pixels in flight would fill
// it, then in_tready drops. Configuration writes on cfg_ are always taken;
// change the geometry only between frames. Reset (rst_n low, synchronous)
// restores the registers to 1024 x 1024, threshold 1, and clears counters
// and the queue; line memory and window contents are left as they are.
module edge_gated_box_blur #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: edge_red, edge_green, edge_blue, pixel_red, pixel_green, pixel_blue
  input  logic [47:0] in_tdata,
  // tuser: pad
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: out_red, out_green, out_blue
  output logic [23:0] out_tdata,
  // tuser: blurred
  output logic        out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic [1:0]  cfg_index,
  input  logic [22:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);
  import egbb_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);       // column index
  localparam int WW  = $clog2(MAX_WIDTH + 1);   // width value
  localparam int RW  = $clog2(MAX_HEIGHT);      // row index
  localparam int HW  = $clog2(MAX_HEIGHT + 1);  // height value
  localparam int ICW = $clog2(MAX_WIDTH + 2);   // warm-up count

  // configuration registers
  logic [CFG_DIM_W-1:0] width_r, height_r;
  logic [THRESH_W-1:0]  thresh_r;
  logic [WW-1:0]        w_eff;
  logic [HW-1:0]        h_eff;

  // counters
  logic [CW-1:0]  in_col_r, in_col_nxt, col_sel;
  logic [ICW-1:0] item_cnt_r, item_cnt_nxt;
  logic [CW-1:0]  out_col_r, out_col_nxt;
  logic [RW-1:0]  out_row_r, out_row_nxt;
  ctl_t           ctl_a;
  logic           accept;

  // line memory: each entry holds {middle line, top line} of one column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_q_r, fwd_data_r, rd_data, mem_wdata;
  logic               fwd_hit_r;

  // stage 1: memory data returns, write back, shift window
  logic               s1_vld_r;
  ctl_t               s1_ctl_r;
  logic [PIX_W-1:0]   s1_item_r;
  logic [CW-1:0]      s1_addr_r;

  win_t               win_r, win_nxt;
  ctl_t               s2_ctl_r;

  // window arithmetic and result queue
  logic               res_vld;
  res_t               res;
  logic [1:0]         pend;
  res_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FIFO_CNT_W:0]   used;
  logic                  push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:    width_r  <= cfg_data[CFG_DIM_W-1:0];
        CFG_FRAME_HEIGHT:   height_r <= cfg_data[CFG_DIM_W-1:0];
        CFG_EDGE_THRESHOLD: thresh_r <= cfg_data;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // clamp geometry to 1..MAX
  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_r);
    end
  end

  assign accept = in_tvalid && in_tready;

  // position bookkeeping happens at acceptance; it needs no pixel data
  always_comb begin
    col_sel      = (WW'(in_col_r) >= w_eff) ? '0 : in_col_r;
    in_col_nxt   = in_col_r;
    item_cnt_nxt = item_cnt_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    ctl_a        = '0;
    if (accept) begin
      in_col_nxt = (WW'(col_sel) + WW'(1) >= w_eff) ? '0 : col_sel + CW'(1);
      if (item_cnt_r < ICW'(w_eff) + ICW'(1)) begin
        item_cnt_nxt = item_cnt_r + ICW'(1);
      end else begin
        ctl_a.res      = 1'b1;
        ctl_a.interior = (out_col_r != '0) && (out_row_r != '0) &&
                         (WW'(out_col_r) + WW'(1) < w_eff) &&
                         (HW'(out_row_r) + HW'(1) < h_eff);
        ctl_a.last     = (HW'(out_row_r) + HW'(1) >= h_eff) &&
                         (WW'(out_col_r) + WW'(1) >= w_eff);
        if (ctl_a.last) begin
          // end of frame: restart all positions
          item_cnt_nxt = '0;
          in_col_nxt   = '0;
          out_col_nxt  = '0;
          out_row_nxt  = '0;
        end else if (WW'(out_col_r) + WW'(1) >= w_eff) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + RW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      item_cnt_r <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_vld_r   <= 1'b0;
      s1_ctl_r   <= '0;
      s2_ctl_r   <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      item_cnt_r <= item_cnt_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      s1_vld_r   <= accept;
      s1_ctl_r   <= accept ? ctl_a : '0;
      s2_ctl_r   <= s1_vld_r ? s1_ctl_r : '0;
    end
  end

  // Stage 1 writes the column that its request read at acceptance. When the next
  // request reads that same column (one-pixel rows), forward the write data.
  always_comb begin
    rd_data   = fwd_hit_r ? fwd_data_r : mem_q_r;
    mem_wdata = {s1_item_r, rd_data[2*PIX_W-1:PIX_W]};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r  <= in_tuser ? '0 : in_tdata;
      s1_addr_r  <= col_sel;
      fwd_hit_r  <= s1_vld_r && (s1_addr_r == col_sel);
      fwd_data_r <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      line_mem[s1_addr_r] <= mem_wdata;
    end
    if (accept) begin
      mem_q_r <= line_mem[col_sel];
    end
  end

  // shift the window left and load the new column: top, middle, incoming
  always_comb begin
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = rd_data[PIX_W-1:0];
    win_nxt[1][2] = rd_data[2*PIX_W-1:PIX_W];
    win_nxt[2][2] = s1_item_r;
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      win_r <= win_nxt;
    end
  end

  egbb_grad u_grad (
    .clk     (clk),
    .rst_n   (rst_n),
    .win     (win_r),
    .ctl     (s2_ctl_r),
    .thresh  (thresh_r),
    .res_vld (res_vld),
    .res     (res),
    .pend    (pend)
  );

  // Result queue. Admit a request only while the queue can hold every
  // result still in flight, so the pipeline never has to stall.
  assign push = res_vld;
  assign pop  = out_tvalid && out_tready;
  assign used = (FIFO_CNT_W+1)'(cnt_r) + (FIFO_CNT_W+1)'(pend)
              + (FIFO_CNT_W+1)'(s1_ctl_r.res) + (FIFO_CNT_W+1)'(s2_ctl_r.res);
  assign in_tready = used < (FIFO_CNT_W+1)'(FIFO_DEPTH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = fifo_r[rd_ptr_r].rgb;
  assign out_tuser  = fifo_r[rd_ptr_r].blurred;
  assign out_tlast  = fifo_r[rd_ptr_r].last;

endmodule

### tb/edge_gated_box_blur_test.sv
`timescale 1ns / 100ps
// Self-checking bench for edge_gated_box_blur: raster frames of shaped and random
// pixels against a pixel-accurate predictor, checked in order on the out_ stream.
// Depends on egbb_pkg and the edge_gated_box_blur RTL.
module edge_gated_box_blur_test;
  import egbb_pkg::*;

  localparam int MAX_DIM = 1024;
  localparam int SETTLE_CYCLES = 16;     // well past the result latency
  localparam int CYCLE_LIMIT = 600000;
  localparam int GAP_PCT = 29;
  localparam int RANDOM_ITEMS = 700;
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;      // index with no register behind it
  localparam logic [22:0] THRESH_TOP = 23'd6242400;
  localparam logic [22:0] STEP_ENERGY = 23'd3121200; // 3 * 1020^2, vertical step edge

  typedef enum int {SCENE_NOISE, SCENE_SMOOTH, SCENE_BLOCKS, SCENE_FLAT, SCENE_STEP} scene_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [1:0]  cfg_index;
  logic [22:0] cfg_data;
  logic        cfg_valid;
  logic        cfg_ready;

  // Predictor copy of the block: registers, line rows, window and raster counters.
  bit [10:0]   width_reg;
  bit [10:0]   height_reg;
  bit [22:0]   thresh_reg;
  bit [47:0]   line_mem [2][MAX_DIM];
  bit [47:0]   win [3][3];
  int unsigned fill_cnt, in_col, pix_col, pix_row;
  res_t        blur_expect_q[$];
  res_t        head_px;

  int unsigned items_sent = 0;
  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  bit          gaps_on = 1'b1;

  edge_gated_box_blur dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("edge_gated_box_blur_test: errors");
      $finish;
    end
  end

  // Geometry registers clamp to 1..MAX, zero included.
  function automatic int unsigned eff_dim(bit [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int chan_of(bit [47:0] p, int k);
    return int'(p[8*k +: 8]);
  endfunction

  // Advance the predictor by one accepted request and queue the pixel it releases.
  function automatic void predict_pixel(bit [47:0] data, bit pad);
    int unsigned w, h, c;
    int gx, gy, v, k, a, b, r;
    longint unsigned energy;
    bit [47:0] item;
    bit interior, edge_hit;
    res_t px;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    item = pad ? 48'd0 : data;
    c = (in_col >= w) ? 0 : in_col;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_mem[0][c];
    win[1][2] = line_mem[1][c];
    win[2][2] = item;
    line_mem[0][c] = win[1][2];
    line_mem[1][c] = item;
    in_col = (c + 1 >= w) ? 0 : c + 1;

    // warm-up: the first W+1 requests of a frame only fill the rows
    if (fill_cnt < w + 1) begin
      fill_cnt++;
      return;
    end

    interior = pix_col >= 1 && pix_row >= 1 && pix_col + 1 < w && pix_row + 1 < h;
    edge_hit = 1'b0;
    if (interior) begin
      energy = 0;
      for (k = 0; k < 3; k++) begin
        gx = (chan_of(win[0][2], k) + 2 * chan_of(win[1][2], k) + chan_of(win[2][2], k))
           - (chan_of(win[0][0], k) + 2 * chan_of(win[1][0], k) + chan_of(win[2][0], k));
        gy = (chan_of(win[2][0], k) + 2 * chan_of(win[2][1], k) + chan_of(win[2][2], k))
           - (chan_of(win[0][0], k) + 2 * chan_of(win[0][1], k) + chan_of(win[0][2], k));
        energy += longint'(gx * gx + gy * gy);
      end
      edge_hit = energy >= thresh_reg;
    end
    for (k = 0; k < 3; k++) begin
      if (edge_hit) begin
        v = 0;
        for (a = 0; a < 3; a++)
          for (b = 0; b < 3; b++)
            v += chan_of(win[a][b], 3 + k) / 9;
      end else begin
        v = chan_of(win[1][1], 3 + k);
      end
      px.rgb[8*k +: 8] = v[7:0];
    end
    px.blurred = edge_hit;
    px.last = pix_row + 1 >= h && pix_col + 1 >= w;
    blur_expect_q.push_back(px);

    if (px.last) begin
      fill_cnt = 0;
      in_col = 0;
      pix_col = 0;
      pix_row = 0;
    end else if (pix_col + 1 >= w) begin
      pix_col = 0;
      pix_row++;
    end else begin
      pix_col++;
    end
  endfunction

  function automatic void note_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("cycle %0d: %s", cycle_cnt, msg);
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) note_fault($sformatf("%s expected %h, got %h", name, want, got));
  endtask

  // Receiver: random stalls with occasional long holds so the result queue fills
  // and in_tready drops; no stalls at all while gaps are off.
  always @(posedge clk) begin
    if (!gaps_on) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(199) == 0) begin
      stall_left <= $urandom_range(8, 24);
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= 27);
    end
  end

  // Compare every accepted output pixel against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (blur_expect_q.size() == 0) begin
        note_fault($sformatf("unexpected pixel %h blurred %b last %b",
                             out_tdata, out_tuser, out_tlast));
      end else begin
        head_px = blur_expect_q.pop_front();
        check_field("red", head_px.rgb[7:0], out_tdata[7:0]);
        check_field("green", head_px.rgb[15:8], out_tdata[15:8]);
        check_field("blue", head_px.rgb[23:16], out_tdata[23:16]);
        check_field("blurred", 8'(head_px.blurred), 8'(out_tuser));
        check_field("frame_last", 8'(head_px.last), 8'(out_tlast));
      end
    end
  end

  // Send one request; valid stays high after acceptance unless the next call idles.
  task automatic send_item(bit [47:0] data, bit pad);
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= data;
    in_tuser <= pad;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(data, pad);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted pixel is out and the pipe is empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (blur_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [22:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:    width_reg = value[10:0];
      CFG_FRAME_HEIGHT:   height_reg = value[10:0];
      CFG_EDGE_THRESHOLD: thresh_reg = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [47:0] make_pixel(scene_t s, int unsigned col, int unsigned fw);
    bit [23:0] edge_rgb, color;
    int k;
    color = 24'($urandom);
    edge_rgb = 24'($urandom);
    case (s)
      SCENE_SMOOTH:
        for (k = 0; k < 3; k++) edge_rgb[8*k +: 8] = 8'(96 + $urandom_range(0, 7));
      SCENE_BLOCKS:
        for (k = 0; k < 3; k++) edge_rgb[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      SCENE_FLAT:
        edge_rgb = 24'hFFFFFF;
      SCENE_STEP: begin
        // dark field with a bright right column, full-scale color
        edge_rgb = (col == fw - 1) ? 24'hFFFFFF : 24'h000000;
        color = 24'hFFFFFF;
      end
      default: ;
    endcase
    return {color, edge_rgb};
  endfunction

  // One whole frame at the current geometry, then W+1 pads to flush it.
  // pad_pct replaces that share of pixels by pads, which count as black pixels.
  task automatic send_frame(scene_t s, int pad_pct);
    int unsigned fw, fh, row, col;
    fw = eff_dim(width_reg);
    fh = eff_dim(height_reg);
    for (row = 0; row < fh; row++)
      for (col = 0; col < fw; col++)
        send_item(make_pixel(s, col, fw), $urandom_range(99) < pad_pct);
    repeat (fw + 1) send_item(48'({$urandom, $urandom}), 1'b1);
  endtask

  // Threshold left at its reset value of 1: flat edge image stays unblurred.
  task automatic test_reset_threshold();
    write_reg(CFG_FRAME_WIDTH, 23'd3);
    write_reg(CFG_FRAME_HEIGHT, 23'd3);
    send_frame(SCENE_NOISE, 0);
    send_frame(SCENE_FLAT, 0);
  endtask

  // Edge decision is "at or above": hit the step energy exactly, then miss by one.
  task automatic test_threshold_bounds();
    settle();
    write_reg(CFG_EDGE_THRESHOLD, STEP_ENERGY);
    send_frame(SCENE_STEP, 0);
    settle();
    write_reg(CFG_EDGE_THRESHOLD, STEP_ENERGY + 23'd1);
    send_frame(SCENE_STEP, 0);
    settle();
    write_reg(CFG_EDGE_THRESHOLD, 23'd0);
    send_frame(SCENE_FLAT, 0);
    settle();
    write_reg(CFG_EDGE_THRESHOLD, THRESH_TOP);
    send_frame(SCENE_BLOCKS, 0);
  endtask

  // Degenerate frames: zero clamps to one, upper write bits are dropped,
  // frames without interior, the spare index, pads inside a frame.
  task automatic test_small_geometry();
    settle();
    write_reg(CFG_FRAME_WIDTH, 23'd0);
    write_reg(CFG_FRAME_HEIGHT, 23'd0);
    write_reg(CFG_EDGE_THRESHOLD, 23'd0);
    send_frame(SCENE_NOISE, 0);
    settle();
    write_reg(CFG_FRAME_WIDTH, 23'h7FF802);
    write_reg(CFG_FRAME_HEIGHT, 23'h7FF805);
    send_frame(SCENE_NOISE, 0);
    settle();
    write_reg(CFG_FRAME_WIDTH, 23'd5);
    write_reg(CFG_FRAME_HEIGHT, 23'd1);
    send_frame(SCENE_NOISE, 0);
    settle();
    write_reg(CFG_SPARE_IDX, 23'($urandom));
    write_reg(CFG_FRAME_WIDTH, 23'd4);
    write_reg(CFG_FRAME_HEIGHT, 23'd4);
    write_reg(CFG_EDGE_THRESHOLD, 23'd300000);
    send_frame(SCENE_NOISE, 25);
  endtask

  // Tallest frame (height clamped from above), one pixel wide to keep it short.
  task automatic test_max_geometry();
    settle();
    write_reg(CFG_FRAME_WIDTH, 23'd1);
    write_reg(CFG_FRAME_HEIGHT, 23'd2047);
    send_frame(SCENE_BLOCKS, 1);
  endtask

  // Random small frames, often back to back, with new settings between some.
  task automatic test_random_frames();
    int unsigned start, done;
    logic [22:0] thr;
    start = items_sent;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      gaps_on = !(done >= 250 && done < 550);
      if ($urandom_range(9) < 6) begin
        settle();
        if ($urandom_range(19) == 0) write_reg(CFG_FRAME_WIDTH, 23'd0);
        else if ($urandom_range(9) == 0) write_reg(CFG_FRAME_WIDTH, 23'($urandom_range(13, 48)));
        else write_reg(CFG_FRAME_WIDTH, 23'($urandom_range(1, 12)));
        write_reg(CFG_FRAME_HEIGHT, 23'($urandom_range(0, 9)));
        case ($urandom_range(0, 4))
          0:       thr = 23'($urandom_range(0, 64));
          1:       thr = 23'($urandom_range(0, 20000));
          2, 3:    thr = 23'($urandom_range(20000, 900000));
          default: thr = 23'($urandom_range(900000, THRESH_TOP));
        endcase
        write_reg(CFG_EDGE_THRESHOLD, thr);
      end
      send_frame(scene_t'($urandom_range(0, 3)), $urandom_range(0, 1) ? 0 : 4);
      done = items_sent - start;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    thresh_reg = THRESH_RST;
    fill_cnt = 0;
    in_col = 0;
    pix_col = 0;
    pix_row = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_threshold();
    test_threshold_bounds();
    test_small_geometry();
    test_max_geometry();
    test_random_frames();

    // drain; any pixel arriving during the hold is flagged as unexpected
    settle();
    if (fault_cnt == 0) begin
      $display("edge_gated_box_blur_test: clean");
    end else begin
      $display("edge_gated_box_blur_test: errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/egbb_pkg.sv
rtl/egbb_grad.sv
rtl/edge_gated_box_blur.sv
tb/edge_gated_box_blur_test.sv
